[hdl/assert_macros.svh]
// Assertion macros for the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/tcf_pkg.sv]
// Shared widths, constants, angle table and controller/datapath bundles
// for the tilt complementary filter. No dependencies.
package tcf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int DT_W     = 20;
  localparam int WEIGHT_W = 16;
  localparam int FUSED_W  = 17;
  localparam int ACCEL_W  = 16;

  localparam logic [WEIGHT_W-1:0] GYRO_WEIGHT_RESET = 16'd32113;
  localparam int WEIGHT_ONE = 32768;

  localparam int GYRO_SCALE   = 62500;
  localparam int PITCH_LIMIT  = 46080;
  localparam int ACCEL_LIMIT  = 23040;

  // CORDIC
  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_TABLE_LEN = 24;
  localparam int CORDIC_RUNS     = (CORDIC_STEPS > ANGLE_TABLE_LEN) ?
                                   ANGLE_TABLE_LEN : CORDIC_STEPS;
  localparam int CNT_W           = $clog2(ANGLE_TABLE_LEN);
  localparam int CORDIC_W        = 34;
  localparam int ANGLE_W         = 25;
  localparam int ATAN_W          = 22;

  // Square root: 32-bit sum of squares scaled by 2^28, two digits a cycle
  localparam int SQ_W           = 32;
  localparam int ROOT_IN_W      = SQ_W + 28;
  localparam int ROOT_W         = ROOT_IN_W / 2;
  localparam int ROOT_REM_W     = ROOT_W + 4;
  localparam int ROOT_PER_CYCLE = 2;
  localparam int ROOT_CYCLES    = ROOT_W / ROOT_PER_CYCLE;

  // Blend and rounded division by 2^17 * 15625
  localparam int RDT_W        = 37;
  localparam int PE_W         = 34;
  localparam int GYRO_W       = 38;
  localparam int GYRO_LO_W    = 20;
  localparam int PL_W         = WEIGHT_W + GYRO_LO_W;
  localparam int PH_W         = WEIGHT_W + 1 + GYRO_W - GYRO_LO_W;
  localparam int A62_W        = 32;
  localparam int AB_W         = A62_W + 17;
  localparam int NUM_W        = 56;
  localparam int DIV_SHIFT    = 17;
  localparam int DIV_BASE     = 15625;
  localparam int HALF_DIVISOR = 1024000000;
  localparam int QUOT_W       = 16;
  localparam int QUOT_LIMIT   = (PITCH_LIMIT + 1) * DIV_BASE;
  localparam int DREM_W       = 30;

  // Division by 15625 as a multiply by ceil(2^44 / 15625), exact below 2^30
  localparam int RECIP_W      = 31;
  localparam int RECIP_SHIFT  = 44;
  localparam int DPROD_W      = DREM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 31'd1125899907;
  localparam int DIV_CYCLES   = 1;

  localparam logic [CNT_W-1:0] ROOT_LAST   = CNT_W'(ROOT_CYCLES - 1);
  localparam logic [CNT_W-1:0] ROTATE_LAST = CNT_W'(CORDIC_RUNS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST    = CNT_W'(DIV_CYCLES - 1);

  // atan(2^-i) in degrees * 2^16, rounded to nearest
  function automatic logic [ATAN_W-1:0] atan_entry(input logic [CNT_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic             load_in;
    logic             square;
    logic             sum;
    logic             root_step;
    logic             cordic_init;
    logic             cordic_step;
    logic [CNT_W-1:0] cordic_idx;
    logic             round;
    logic             scale;
    logic             blend;
    logic             num;
    logic             mag;
    logic             div_init;
    logic             div_step;
    logic             finish;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

[hdl/tcf_if.sv]
// Valid/ready channel interfaces for samples and results.
// Depends on tcf_pkg for field widths.
interface tcf_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [tcf_pkg::SAMPLE_W-1:0] accel_x;
  logic signed [tcf_pkg::SAMPLE_W-1:0] accel_y;
  logic signed [tcf_pkg::SAMPLE_W-1:0] accel_z;
  logic signed [tcf_pkg::SAMPLE_W-1:0] gyro_rate;
  logic        [tcf_pkg::DT_W-1:0]     delta_time;

  modport source(output valid, accel_x, accel_y, accel_z, gyro_rate, delta_time,
                 input ready);
  modport sink(input valid, accel_x, accel_y, accel_z, gyro_rate, delta_time,
               output ready);
endinterface

interface tcf_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [tcf_pkg::FUSED_W-1:0] fused_pitch;
  logic signed [tcf_pkg::ACCEL_W-1:0] accel_pitch;

  modport source(output valid, fused_pitch, accel_pitch, input ready);
  modport sink(input valid, fused_pitch, accel_pitch, output ready);
endinterface

[hdl/tcf_ctrl.sv]
// Sequencer for the tilt filter: steps the datapath through squares, root,
// CORDIC, blend and division. Depends on tcf_pkg.
module tcf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tcf_pkg::status_t status,
  output tcf_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SQUARE = 4'd1;
  localparam logic [3:0] S_SUM    = 4'd2;
  localparam logic [3:0] S_ROOT   = 4'd3;
  localparam logic [3:0] S_CINIT  = 4'd4;
  localparam logic [3:0] S_ROTATE = 4'd5;
  localparam logic [3:0] S_ROUND  = 4'd6;
  localparam logic [3:0] S_SCALE  = 4'd7;
  localparam logic [3:0] S_BLEND  = 4'd8;
  localparam logic [3:0] S_NUM    = 4'd9;
  localparam logic [3:0] S_MAG    = 4'd10;
  localparam logic [3:0] S_DINIT  = 4'd11;
  localparam logic [3:0] S_DIVIDE = 4'd12;
  localparam logic [3:0] S_FINISH = 4'd13;

  logic [3:0]                state;
  logic [3:0]                state_next;
  logic [tcf_pkg::CNT_W-1:0] cnt;
  logic [tcf_pkg::CNT_W-1:0] cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    cmd            = '0;
    cmd.cordic_idx = cnt;
    in_ready       = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        cnt_next   = '0;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (cnt == tcf_pkg::ROOT_LAST) begin
          cnt_next   = '0;
          state_next = S_CINIT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_CINIT: begin
        cmd.cordic_init = 1'b1;
        cnt_next        = '0;
        state_next      = S_ROTATE;
      end
      S_ROTATE: begin
        cmd.cordic_step = 1'b1;
        if (cnt == tcf_pkg::ROTATE_LAST) begin
          cnt_next   = '0;
          state_next = S_ROUND;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_ROUND: begin
        cmd.round  = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_BLEND;
      end
      S_BLEND: begin
        cmd.blend  = 1'b1;
        state_next = S_NUM;
      end
      S_NUM: begin
        cmd.num    = 1'b1;
        state_next = S_MAG;
      end
      S_MAG: begin
        cmd.mag    = 1'b1;
        state_next = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = S_DIVIDE;
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (cnt == tcf_pkg::DIV_LAST) begin
          cnt_next   = '0;
          state_next = S_FINISH;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_FINISH: begin
        // hold until the output register can take the result
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

endmodule

[hdl/tcf_datapath.sv]
// Datapath of the tilt filter: square root, CORDIC, gyro integration,
// blend, rounding division and output register. Depends on tcf_pkg.
module tcf_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  tcf_pkg::cmd_t                       cmd,
  output tcf_pkg::status_t                    status,
  input  logic                                cfg_we,
  input  logic        [tcf_pkg::WEIGHT_W-1:0] cfg_wdata,
  input  logic signed [tcf_pkg::SAMPLE_W-1:0] accel_x,
  input  logic signed [tcf_pkg::SAMPLE_W-1:0] accel_y,
  input  logic signed [tcf_pkg::SAMPLE_W-1:0] accel_z,
  input  logic signed [tcf_pkg::SAMPLE_W-1:0] gyro_rate,
  input  logic        [tcf_pkg::DT_W-1:0]     delta_time,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [tcf_pkg::FUSED_W-1:0]  fused_pitch,
  output logic signed [tcf_pkg::ACCEL_W-1:0]  accel_pitch
);

  // configuration and state
  logic        [tcf_pkg::WEIGHT_W-1:0] gyro_weight;
  logic signed [tcf_pkg::FUSED_W-1:0]  pitch;

  // latched sample
  logic signed [tcf_pkg::SAMPLE_W-1:0] ax;
  logic signed [tcf_pkg::SAMPLE_W-1:0] ay;
  logic signed [tcf_pkg::SAMPLE_W-1:0] az;
  logic signed [tcf_pkg::SAMPLE_W-1:0] rate;
  logic        [tcf_pkg::DT_W-1:0]     dt;
  logic        [tcf_pkg::WEIGHT_W-1:0] weight;

  // working registers
  logic signed [tcf_pkg::SQ_W-1:0]       ysq;
  logic signed [tcf_pkg::SQ_W-1:0]       zsq;
  logic signed [tcf_pkg::RDT_W-1:0]      rdt;
  logic signed [tcf_pkg::PE_W-1:0]       pe;
  logic        [tcf_pkg::ROOT_IN_W-1:0]  src;
  logic        [tcf_pkg::ROOT_REM_W-1:0] rem;
  logic        [tcf_pkg::ROOT_W-1:0]     root;
  logic signed [tcf_pkg::CORDIC_W-1:0]   cx;
  logic signed [tcf_pkg::CORDIC_W-1:0]   cy;
  logic signed [tcf_pkg::ANGLE_W-1:0]    ang;
  logic signed [tcf_pkg::GYRO_W-1:0]     gyro;
  logic signed [tcf_pkg::ACCEL_W-1:0]    acc;
  logic        [tcf_pkg::PL_W-1:0]       pl;
  logic signed [tcf_pkg::PH_W-1:0]       ph;
  logic signed [tcf_pkg::A62_W-1:0]      a62;
  logic signed [tcf_pkg::NUM_W-1:0]      wg;
  logic signed [tcf_pkg::AB_W-1:0]       ab;
  logic signed [tcf_pkg::NUM_W-1:0]      num;
  logic        [tcf_pkg::NUM_W-1:0]      mag;
  logic                                  neg;
  logic                                  sat;
  logic        [tcf_pkg::DREM_W-1:0]     drem;
  logic        [tcf_pkg::QUOT_W-1:0]     quo;

  // combinational results
  logic signed [tcf_pkg::SQ_W-1:0]       ysq_w;
  logic signed [tcf_pkg::SQ_W-1:0]       zsq_w;
  logic signed [tcf_pkg::RDT_W-1:0]      rdt_w;
  logic signed [tcf_pkg::PE_W-1:0]       pe_w;
  logic        [tcf_pkg::SQ_W-1:0]       sq_w;
  logic        [tcf_pkg::ROOT_REM_W-1:0] r_v;
  logic        [tcf_pkg::ROOT_REM_W-1:0] r_t;
  logic        [tcf_pkg::ROOT_REM_W-1:0] r_trial;
  logic        [tcf_pkg::ROOT_W-1:0]     q_v;
  logic        [tcf_pkg::ROOT_IN_W-1:0]  s_v;
  logic signed [tcf_pkg::CORDIC_W-1:0]   dx;
  logic signed [tcf_pkg::CORDIC_W-1:0]   dy;
  logic signed [tcf_pkg::ANGLE_W-1:0]    tab;
  logic                                  y_pos;
  logic signed [tcf_pkg::CORDIC_W-1:0]   ax_ext;
  logic        [tcf_pkg::ANGLE_W-1:0]    ang_abs;
  logic        [tcf_pkg::ANGLE_W-1:0]    ang_q;
  logic        [tcf_pkg::ACCEL_W-1:0]    ang_lim;
  logic signed [tcf_pkg::ACCEL_W-1:0]    acc_w;
  logic        [tcf_pkg::PL_W-1:0]       pl_w;
  logic signed [tcf_pkg::PH_W-1:0]       ph_w;
  logic signed [tcf_pkg::A62_W-1:0]      a62_w;
  logic        [tcf_pkg::WEIGHT_W-1:0]   omw;
  logic signed [tcf_pkg::AB_W-1:0]       ab_w;
  logic signed [tcf_pkg::NUM_W-1:0]      num_abs;
  logic        [tcf_pkg::NUM_W-tcf_pkg::DIV_SHIFT-1:0] mq;
  logic        [tcf_pkg::DPROD_W-1:0]    dprod;
  logic        [tcf_pkg::QUOT_W-1:0]     q_mag;
  logic signed [tcf_pkg::FUSED_W-1:0]    fused_w;

  // products, one rank of multipliers per step
  assign ysq_w = $signed({{16{ay[15]}}, ay}) * $signed({{16{ay[15]}}, ay});
  assign zsq_w = $signed({{16{az[15]}}, az}) * $signed({{16{az[15]}}, az});
  assign sq_w  = ysq + zsq;
  assign rdt_w = $signed({{21{rate[15]}}, rate}) * $signed({17'd0, dt});
  assign pe_w  = $signed({{17{pitch[16]}}, pitch})
               * $signed(tcf_pkg::PE_W'(tcf_pkg::GYRO_SCALE));

  // two digits of the square root
  always_comb begin
    r_v = rem;
    q_v = root;
    s_v = src;
    r_t = '0;
    r_trial = '0;
    for (int k = 0; k < tcf_pkg::ROOT_PER_CYCLE; k++) begin
      r_t     = {r_v[tcf_pkg::ROOT_REM_W-3:0], s_v[tcf_pkg::ROOT_IN_W-1 -: 2]};
      r_trial = {2'b00, q_v, 2'b01};
      if (r_t >= r_trial) begin
        r_v = r_t - r_trial;
        q_v = {q_v[tcf_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        r_v = r_t;
        q_v = {q_v[tcf_pkg::ROOT_W-2:0], 1'b0};
      end
      s_v = {s_v[tcf_pkg::ROOT_IN_W-3:0], 2'b00};
    end
  end

  // one CORDIC vectoring rotation
  assign ax_ext = $signed({{(tcf_pkg::CORDIC_W - tcf_pkg::SAMPLE_W){ax[15]}}, ax});
  assign dx     = cy >>> cmd.cordic_idx;
  assign dy     = cx >>> cmd.cordic_idx;
  assign tab    = $signed({{(tcf_pkg::ANGLE_W - tcf_pkg::ATAN_W){1'b0}},
                           tcf_pkg::atan_entry(cmd.cordic_idx)});
  assign y_pos  = !cy[tcf_pkg::CORDIC_W-1] && (cy != '0);

  // angle to 1/256 degree, half away from zero, then clamp
  assign ang_abs = ang[tcf_pkg::ANGLE_W-1] ? 25'(-ang) : 25'(ang);
  assign ang_q   = (ang_abs + 25'd128) >> 8;
  assign ang_lim = (ang_q > 25'(tcf_pkg::ACCEL_LIMIT)) ?
                   16'(tcf_pkg::ACCEL_LIMIT) : ang_q[tcf_pkg::ACCEL_W-1:0];
  assign acc_w   = (ax == '0) ? '0 :
                   (ang[tcf_pkg::ANGLE_W-1] ? -$signed(ang_lim) : $signed(ang_lim));

  // blend terms
  assign pl_w  = {20'd0, weight} * {16'd0, gyro[tcf_pkg::GYRO_LO_W-1:0]};
  assign ph_w  = $signed({19'd0, weight})
               * $signed({{17{gyro[tcf_pkg::GYRO_W-1]}},
                          gyro[tcf_pkg::GYRO_W-1:tcf_pkg::GYRO_LO_W]});
  assign a62_w = $signed({{16{acc[15]}}, acc})
               * $signed(tcf_pkg::A62_W'(tcf_pkg::GYRO_SCALE));
  assign omw   = 16'(17'(tcf_pkg::WEIGHT_ONE) - {1'b0, weight});
  assign ab_w  = $signed({33'd0, omw}) * $signed({{17{a62[31]}}, a62});

  assign num_abs = num[tcf_pkg::NUM_W-1] ? -num : num;
  assign mq      = mag[tcf_pkg::NUM_W-1:tcf_pkg::DIV_SHIFT];

  // quotient by 15625 through the reciprocal multiply
  assign dprod = {{tcf_pkg::RECIP_W{1'b0}}, drem}
               * {{tcf_pkg::DREM_W{1'b0}}, tcf_pkg::DIV_RECIP};

  assign q_mag   = sat ? 16'(tcf_pkg::PITCH_LIMIT) : quo;
  assign fused_w = neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

  assign status.out_free = !out_valid || out_ready;

  // control state: weight register, stored pitch, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_weight <= tcf_pkg::GYRO_WEIGHT_RESET;
      pitch       <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        gyro_weight <= cfg_wdata;
      end
      if (cmd.finish) begin
        pitch     <= fused_w;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ax     <= accel_x;
      ay     <= accel_y;
      az     <= accel_z;
      rate   <= gyro_rate;
      dt     <= delta_time;
      weight <= (gyro_weight > 16'(tcf_pkg::WEIGHT_ONE)) ?
                16'(tcf_pkg::WEIGHT_ONE) : gyro_weight;
    end
    if (cmd.square) begin
      ysq <= ysq_w;
      zsq <= zsq_w;
    end
    if (cmd.sum) begin
      src  <= {sq_w, 28'd0};
      rem  <= '0;
      root <= '0;
      rdt  <= rdt_w;
      pe   <= pe_w;
    end
    if (cmd.root_step) begin
      src  <= s_v;
      rem  <= r_v;
      root <= q_v;
    end
    if (cmd.cordic_init) begin
      cx   <= $signed({{(tcf_pkg::CORDIC_W - tcf_pkg::ROOT_W){1'b0}}, root});
      cy   <= -(ax_ext <<< 14);
      ang  <= '0;
      gyro <= $signed({{(tcf_pkg::GYRO_W - tcf_pkg::PE_W){pe[tcf_pkg::PE_W-1]}}, pe})
            + $signed({rdt[tcf_pkg::RDT_W-1], rdt});
    end
    if (cmd.cordic_step) begin
      if (y_pos) begin
        cx  <= cx + dx;
        cy  <= cy - dy;
        ang <= ang + tab;
      end else begin
        cx  <= cx - dx;
        cy  <= cy + dy;
        ang <= ang - tab;
      end
    end
    if (cmd.round) begin
      acc <= acc_w;
      pl  <= pl_w;
      ph  <= ph_w;
    end
    if (cmd.scale) begin
      a62 <= a62_w;
      wg  <= ($signed({{(tcf_pkg::NUM_W - tcf_pkg::PH_W){ph[tcf_pkg::PH_W-1]}}, ph})
              <<< tcf_pkg::GYRO_LO_W)
           + $signed({{(tcf_pkg::NUM_W - tcf_pkg::PL_W){1'b0}}, pl});
    end
    if (cmd.blend) begin
      ab <= ab_w;
    end
    if (cmd.num) begin
      num <= wg + $signed({{(tcf_pkg::NUM_W - tcf_pkg::AB_W){ab[tcf_pkg::AB_W-1]}}, ab});
    end
    if (cmd.mag) begin
      neg <= num[tcf_pkg::NUM_W-1];
      mag <= 56'(num_abs) + 56'(tcf_pkg::HALF_DIVISOR);
    end
    if (cmd.div_init) begin
      sat  <= (mq >= 39'(tcf_pkg::QUOT_LIMIT));
      drem <= mq[tcf_pkg::DREM_W-1:0];
    end
    if (cmd.div_step) begin
      quo <= dprod[tcf_pkg::RECIP_SHIFT +: tcf_pkg::QUOT_W];
    end
    if (cmd.finish) begin
      fused_pitch <= fused_w;
      accel_pitch <= acc;
    end
  end

endmodule

[hdl/tilt_complementary_filter.sv]
// Top level of the tilt complementary filter: sequencer plus datapath.
// Depends on tcf_pkg, tcf_if, tcf_ctrl and tcf_datapath.
//
//   Channel   Dir  Handshake     Payload
//   sample    in   valid/ready   accel_x, accel_y, accel_z, gyro_rate, delta_time
//   result    out  valid/ready   fused_pitch, accel_pitch
//   cfg       in   cfg_we        cfg_wdata (gyro_weight, Q1.15)
//
// One request at a time: a result turns valid once the sequencer has stepped through
// squares, sum, root, CORDIC rotations, blend and division, and the next request can
// be taken as soon as the result is valid. The work is set by the square root (two
// digits a cycle), the CORDIC rotations (one a cycle in a shared shift-add unit)
// and the quotient (one reciprocal multiply).
// A finished result waits in the output register; new requests are taken
// while it waits, and the next result holds in the sequencer until it drains.
// Reset (synchronous) clears the stored pitch, reloads gyro_weight to 32113
// and empties the output register.
module tilt_complementary_filter (
  input  logic                                clk,
  input  logic                                rst,
  tcf_sample_if.sink                          sample,
  tcf_result_if.source                        result,
  input  logic                                cfg_we,
  input  logic        [tcf_pkg::WEIGHT_W-1:0] cfg_wdata
);

  tcf_pkg::cmd_t    cmd;
  tcf_pkg::status_t status;
  logic             in_ready;

  // sequencer: owns sample.ready and paces the datapath
  tcf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  assign sample.ready = in_ready;

  // datapath: latches the request, does the arithmetic, holds the result
  tcf_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .accel_x     (sample.accel_x),
    .accel_y     (sample.accel_y),
    .accel_z     (sample.accel_z),
    .gyro_rate   (sample.gyro_rate),
    .delta_time  (sample.delta_time),
    .out_ready   (result.ready),
    .out_valid   (result.valid),
    .fused_pitch (result.fused_pitch),
    .accel_pitch (result.accel_pitch)
  );

endmodule

[hdl/tcf_checker.sv]
// Port-level checks for the tilt complementary filter, bound to the top.
// Depends on assert_macros.svh and tcf_pkg.
`include "assert_macros.svh"

module tcf_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [tcf_pkg::FUSED_W-1:0] fused_pitch,
  input logic signed [tcf_pkg::ACCEL_W-1:0] accel_pitch
);

  // result must hold until taken
  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result dropped")

  // fused pitch saturates at 180 degrees
  `ASSERT_CLK(a_fused_range, clk, rst, out_valid |-> (fused_pitch >= -17'sd46080 && fused_pitch <= 17'sd46080), "fused pitch out of range")

  // accelerometer pitch clamps at 90 degrees
  `ASSERT_CLK(a_accel_range, clk, rst, out_valid |-> (accel_pitch >= -16'sd23040 && accel_pitch <= 16'sd23040), "accel pitch out of range")

  // one request in flight: ready drops right after a request is taken
  `ASSERT_CLK(a_one_in_flight, clk, rst, in_valid && in_ready |=> !in_ready, "second request taken")

  // reset empties the output register
  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "result valid after reset")

endmodule

bind tilt_complementary_filter tcf_checker u_tcf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (sample.valid),
  .in_ready    (sample.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .fused_pitch (result.fused_pitch),
  .accel_pitch (result.accel_pitch)
);

[tb/sv/tilt_complementary_filter_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for tilt_complementary_filter: drives IMU sample requests,
// predicts fused and accelerometer pitch, and compares every result in order.
// Depends on tcf_pkg, tcf_if and the filter RTL.
module tilt_complementary_filter_tb;

  // Cycles with no accepted request on either channel before the run is called hung.
  // The slowest legal request is one request's work plus the longest sender gap and the
  // longest result stall, so this is far above any correct run.
  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 60;
  localparam int PHASE_ITEMS  = 190;
  localparam int PHASE_COUNT  = 7;
  localparam int REPORT_LIMIT = 10;

  // Gyro pitch is tracked in 1/16e6 degree; one pitch LSB (1/256 degree) is 62500 of them.
  localparam longint UNITS_PER_LSB = 62500;
  localparam longint FULL_WEIGHT   = 32768;
  localparam longint FUSED_LIMIT   = 46080;
  localparam longint TILT_LIMIT    = 23040;
  localparam int     TABLE_LEN     = 24;
  localparam int     ROTATIONS     = (tcf_pkg::CORDIC_STEPS > TABLE_LEN) ?
                                     TABLE_LEN : tcf_pkg::CORDIC_STEPS;

  typedef struct {
    logic signed [tcf_pkg::SAMPLE_W-1:0] accel_x;
    logic signed [tcf_pkg::SAMPLE_W-1:0] accel_y;
    logic signed [tcf_pkg::SAMPLE_W-1:0] accel_z;
    logic signed [tcf_pkg::SAMPLE_W-1:0] gyro_rate;
    logic        [tcf_pkg::DT_W-1:0]     delta_time;
  } imu_sample_t;

  typedef struct {
    logic signed [tcf_pkg::FUSED_W-1:0] fused_pitch;
    logic signed [tcf_pkg::ACCEL_W-1:0] accel_pitch;
  } pitch_pair_t;

  // Tracks the filter's stored pitch and blend weight, and holds the pitch pairs
  // still owed by the block, oldest first.
  class pitch_tracker;
    longint      angle_step[TABLE_LEN];
    longint      gyro_weight;
    longint      pitch_state;
    pitch_pair_t pending[$];
    int          fault_count;

    function new();
      // atan(2^-i) in degrees * 2^16, rounded to nearest
      angle_step = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                     14668, 7334, 3667, 1833, 917, 458, 229, 115,
                     57, 29, 14, 7, 4, 2, 1, 0};
      gyro_weight = tcf_pkg::GYRO_WEIGHT_RESET;
      pitch_state = 0;
      fault_count = 0;
    endfunction

    function void set_weight(longint w);
      gyro_weight = w;
    endfunction

    // Nearest integer, ties away from zero.
    function longint round_div(longint n, longint d);
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
    endfunction

    function longint clip(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    // Floor of the square root, one result bit at a time from the top.
    function longint root_floor(longint unsigned v);
      longint unsigned r;
      longint unsigned trial;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        trial = r | (64'd1 << b);
        if (trial * trial <= v) r = trial;
      end
      return longint'(r);
    endfunction

    // atan2(-x, |(y, z)|) by vectoring CORDIC, in 1/256 degree.
    function longint tilt_angle(longint ax, longint ay, longint az);
      longint unsigned mag2;
      longint xs, ys, ang, dx, dy;
      if (ax == 0) return 0;
      mag2 = ay * ay + az * az;
      xs = root_floor(mag2 << 28);
      ys = -ax * 16384;
      ang = 0;
      for (int i = 0; i < ROTATIONS; i++) begin
        dx = ys >>> i;
        dy = xs >>> i;
        if (ys > 0) begin
          xs += dx;
          ys -= dy;
          ang += angle_step[i];
        end else begin
          xs -= dx;
          ys += dy;
          ang -= angle_step[i];
        end
      end
      return clip(round_div(ang, 256), TILT_LIMIT);
    endfunction

    function void take_sample(imu_sample_t s);
      longint      w, acc, gyro, blend_num, fused;
      pitch_pair_t want;
      w = (gyro_weight > FULL_WEIGHT) ? FULL_WEIGHT : gyro_weight;
      acc = tilt_angle(longint'(s.accel_x), longint'(s.accel_y), longint'(s.accel_z));
      gyro = pitch_state * UNITS_PER_LSB + longint'(s.gyro_rate) * longint'(s.delta_time);
      blend_num = w * gyro + (FULL_WEIGHT - w) * acc * UNITS_PER_LSB;
      fused = clip(round_div(blend_num, FULL_WEIGHT * UNITS_PER_LSB), FUSED_LIMIT);
      pitch_state = fused;
      want.fused_pitch = tcf_pkg::FUSED_W'(fused);
      want.accel_pitch = tcf_pkg::ACCEL_W'(acc);
      pending.push_back(want);
    endfunction

    function void note_fault(string what);
      fault_count++;
      if (fault_count <= REPORT_LIMIT) $display("%s", what);
    endfunction

    function void match_result(pitch_pair_t got);
      pitch_pair_t want;
      if (pending.size() == 0) begin
        note_fault($sformatf("result with nothing pending: fused_pitch %0d accel_pitch %0d",
                             got.fused_pitch, got.accel_pitch));
        return;
      end
      want = pending.pop_front();
      if (got.fused_pitch !== want.fused_pitch)
        note_fault($sformatf("fused_pitch mismatch: expected %0d, got %0d",
                             want.fused_pitch, got.fused_pitch));
      if (got.accel_pitch !== want.accel_pitch)
        note_fault($sformatf("accel_pitch mismatch: expected %0d, got %0d",
                             want.accel_pitch, got.accel_pitch));
    endfunction
  endclass

  logic                         clk;
  logic                         rst;
  logic                         cfg_we;
  logic [tcf_pkg::WEIGHT_W-1:0] cfg_wdata;

  // When set, both sides run back to back with no gaps or stalls.
  bit calm = 1'b0;
  int stall_cycles = 0;

  pitch_tracker tracker = new();

  tcf_sample_if sample_ch();
  tcf_result_if result_ch();

  tilt_complementary_filter i_dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Idle length for either side: mostly none or a few cycles, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic imu_sample_t sample_of(int ax, int ay, int az, int rate, int dt);
    imu_sample_t s;
    s.accel_x    = tcf_pkg::SAMPLE_W'(ax);
    s.accel_y    = tcf_pkg::SAMPLE_W'(ay);
    s.accel_z    = tcf_pkg::SAMPLE_W'(az);
    s.gyro_rate  = tcf_pkg::SAMPLE_W'(rate);
    s.delta_time = tcf_pkg::DT_W'(dt);
    return s;
  endfunction

  function automatic imu_sample_t random_sample();
    imu_sample_t s;
    int          kind;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      // Sensor near 1 g, tilting slowly, sampled at about a kilohertz.
      s = sample_of(int'($urandom_range(0, 32768)) - 16384,
                    int'($urandom_range(0, 4000)) - 2000,
                    ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(0, 16384)),
                    int'($urandom_range(0, 1600)) - 800,
                    $urandom_range(800, 1200));
    end else if (kind < 70) begin
      // Plausible gravity with violent rotation or long gaps: push toward saturation.
      s = sample_of(int'($urandom_range(0, 32768)) - 16384,
                    int'($urandom_range(0, 4000)) - 2000,
                    int'($urandom_range(0, 32768)) - 16384,
                    $urandom(), $urandom());
    end else begin
      // Anything the fields can carry.
      s = sample_of($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    end
    if ($urandom_range(0, 19) == 0) s.accel_x = '0;
    if ($urandom_range(0, 29) == 0) begin
      s.accel_y = '0;
      s.accel_z = '0;
    end
    return s;
  endfunction

  // Offer one sample request, hold it until the block takes it, then log it.
  task automatic send_sample(imu_sample_t s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid      <= 1'b1;
    sample_ch.accel_x    <= s.accel_x;
    sample_ch.accel_y    <= s.accel_y;
    sample_ch.accel_z    <= s.accel_z;
    sample_ch.gyro_rate  <= s.gyro_rate;
    sample_ch.delta_time <= s.delta_time;
    do @(posedge clk); while (!sample_ch.ready);
    tracker.take_sample(s);
  endtask

  // Drop valid and hold off until every pending pitch pair has come back.
  task automatic drain_results();
    sample_ch.valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic write_weight(int unsigned w);
    cfg_wdata <= tcf_pkg::WEIGHT_W'(w);
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tracker.set_weight(w);
  endtask

  // Result side: check each accepted result, then pick the next ready pattern.
  initial begin
    int          stall;
    pitch_pair_t got;
    stall = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (result_ch.valid && result_ch.ready) begin
        got.fused_pitch = result_ch.fused_pitch;
        got.accel_pitch = result_ch.accel_pitch;
        tracker.match_result(got);
      end
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        stall--;
      end else begin
        result_ch.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    int weights[PHASE_COUNT];
    weights = '{1, 16384, 32767, 50000, 0, 32768, 0};
    weights[PHASE_COUNT-1] = $urandom_range(0, 65535);

    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;
    sample_ch.valid      <= 1'b0;
    sample_ch.accel_x    <= '0;
    sample_ch.accel_y    <= '0;
    sample_ch.accel_z    <= '0;
    sample_ch.gyro_rate  <= '0;
    sample_ch.delta_time <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset weight: geometry corners of the accelerometer path.
    send_sample(sample_of(0, 0, 0, 0, 0));                    // all axes zero
    send_sample(sample_of(0, 16384, -16384, 100, 1000));      // zero x axis
    send_sample(sample_of(-32768, 0, 0, 0, 1000));            // straight up
    send_sample(sample_of(32767, 0, 0, 0, 1000));             // straight down
    send_sample(sample_of(1, -32768, -32768, 0, 1000));       // tiniest angle
    send_sample(sample_of(-1, 32767, 32767, 0, 1000));
    send_sample(sample_of(-32768, -32768, -32768, 32767, 1048575));
    send_sample(sample_of(32767, 32767, 32767, -32768, 1048575));
    send_sample(sample_of(-16384, 0, 16384, -1, 0));

    // Pure gyro: drive the stored pitch into both rails and make sure it never wraps.
    drain_results();
    write_weight(32768);
    send_sample(sample_of(0, 0, 0, 32767, 1048575));
    send_sample(sample_of(0, 0, 0, 32767, 1048575));
    send_sample(sample_of(1000, 0, 16384, -32768, 1048575));
    send_sample(sample_of(-1000, 0, 16384, -32768, 1048575));
    send_sample(sample_of(0, 0, 0, -32768, 1048575));
    send_sample(sample_of(0, 0, 0, 0, 0));

    // Weight above one must act as exactly one.
    drain_results();
    write_weight(65535);
    send_sample(sample_of(0, 0, 0, 32767, 1048575));
    send_sample(sample_of(12345, -200, 16000, -300, 1000));

    // Accelerometer only.
    drain_results();
    write_weight(0);
    send_sample(sample_of(-32768, 0, 1, 5, 5));
    send_sample(sample_of(16384, 16384, 0, 0, 1));
    send_sample(sample_of(0, 0, 0, 32767, 1048575));

    // Random phases, one blend weight each; the second stretch of every phase
    // runs with no idling on either side.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain_results();
      write_weight(weights[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 64 == 0) calm = (n == 64) || ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 149) == 0) drain_results();
        send_sample(random_sample());
      end
    end

    calm = 1'b0;
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.fault_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
